FILE: sv/cfdt_pkg.sv
// shared constants and types for the constant fraction edge timer
package cfdt_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam logic [15:0] FRACTION_RESET = 16'd32768;
    localparam logic [15:0] PEAK_RESET = 16'sh8000;
    localparam int QUOT_BITS = 40;
    localparam int MAG_BITS = 64;

    localparam logic [0:0] ADDR_FRACTION = 1'b0;

    // controller commands to the datapath
    typedef struct packed {
        logic store;      // write sample and update peak
        logic clear;      // clear waveform state
        logic rd_start;   // read scan entry (address from scan index)
        logic scan_init;  // load scan index from peak index
        logic scan_dec;   // step scan index down
        logic lat_cur;    // latch current entry
        logic lat_prev;   // latch previous entry
        logic mul_start;  // form numerator product
        logic div_start;  // start divider
        logic res_load;   // load result register
        logic res_found;  // result marks a crossing
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic can_scan;   // peak positive and not at index zero
        logic cur_ge;     // current latched entry meets threshold
        logic prev_lt;    // previous latched entry below threshold
        logic scan_zero;  // scan index reached zero
        logic scan_one;   // scan index at one, last candidate
        logic div_done;
    } t_stat;

endpackage

FILE: sv/constant_fraction_edge_timer.sv
// constant fraction edge timer top level
//
// usage:
//   s_axis: one waveform as a run of samples, tdata = {time, amplitude}, tlast on
//   the final sample. each sample is one transaction, one per cycle while loading.
//   m_axis: one result transaction per waveform after its last sample.
//   apb: register 0 at address 0 is the threshold fraction (unsigned Q0.16,
//   reset 0x8000).
// scan: after the last sample the controller scans backward from the peak,
//   reading each entry and, for one that meets threshold, its neighbor below
//   (one memory read port, registered data); a radix-2 divider then forms the
//   interpolation, and m_axis_tvalid rises once the result register is loaded.
//   when no scan is needed the result is loaded without scan or divide.
// throughput: samples load at one per cycle while s_axis_tready is high; a waveform
//   then waits for the scan and divide above, during which s_axis_tready is low.
// reset: synchronous active low; peak tracking and counters clear, the stores
//   are not cleared (only entries written in the current waveform are read).
// stall: a result waits in the output register; loading of the next waveform
//   continues while it waits, but a new result is not loaded until it is taken,
//   and s_axis_tready stays low while a finished waveform waits behind it.
module constant_fraction_edge_timer
    import cfdt_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample_amplitude[15:0], sample_time[47:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // found[0], cfd_time[40:1], peak_amplitude[56:41],
                                        // peak_index[66:57], overflow[67], zero[71:68]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_fraction;
    t_cmd        w_cmd;
    t_stat       w_stat;
    logic        w_in_fire;
    logic        w_found, w_ovf;
    logic [39:0] w_time;
    logic [15:0] w_pamp;
    logic [9:0]  w_pidx;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == ADDR_FRACTION) ? {16'd0, r_fraction} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fraction <= FRACTION_RESET;
        end else if (psel && penable && pwrite && paddr[1] == ADDR_FRACTION) begin
            r_fraction <= pwdata[15:0];
        end
    end

    assign w_in_fire = s_axis_tvalid && s_axis_tready;

    cfdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_last      (s_axis_tlast),
        .i_out_taken (m_axis_tvalid && m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    cfdt_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_amp            (s_axis_tdata[15:0]),
        .i_time           (s_axis_tdata[47:16]),
        .i_fraction       (r_fraction),
        .o_stat           (w_stat),
        .o_found          (w_found),
        .o_cfd_time       (w_time),
        .o_peak_amplitude (w_pamp),
        .o_peak_index     (w_pidx),
        .o_overflow       (w_ovf)
    );

    assign m_axis_tdata = {4'd0, w_ovf, w_pidx, w_pamp, w_time, w_found};

    a_no_load_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result overwritten while waiting");
    a_found_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_found) |-> (w_time == 40'd0))
        else $error("time set without crossing");
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_found) |-> ($signed(w_pamp) > 16'sd0 && w_pidx != 10'd0))
        else $error("crossing reported with invalid peak");
endmodule

FILE: sv/cfdt_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module cfdt_div
    import cfdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_BITS-1:0]  i_num,
    input  logic [24:0]          i_den,
    output logic [QUOT_BITS-1:0] o_quot,
    output logic                 o_rem_nz,
    output logic                 o_done
);
    logic [QUOT_BITS-1:0] r_q;
    logic [25:0]          r_rem;
    logic [24:0]          r_den;
    logic [5:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [25:0]          w_try;
    logic [25:0]          w_sub;

    assign w_try = {r_rem[24:0], r_q[QUOT_BITS-1]};
    assign w_sub = w_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QUOT_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient fits QUOT_BITS, so the high dividend bits start below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[QUOT_BITS-1:0];
            r_rem <= 26'(i_num[MAG_BITS-1:QUOT_BITS]);
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[25]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[QUOT_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_try;
                r_q   <= {r_q[QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_quot   = r_q;
    assign o_rem_nz = (r_rem != '0);
    assign o_done   = r_done;
endmodule

FILE: sv/cfdt_datapath.sv
// sample stores, peak tracking, scan registers and interpolation arithmetic
module cfdt_datapath
    import cfdt_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_amp,
    input  logic [31:0] i_time,
    input  logic [15:0] i_fraction,
    output t_stat       o_stat,
    output logic        o_found,
    output logic [39:0] o_cfd_time,
    output logic [15:0] o_peak_amplitude,
    output logic [9:0]  o_peak_index,
    output logic        o_overflow
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [15:0]   mem_amp [MAX_SAMPLES];
    logic [31:0]   mem_time[MAX_SAMPLES];

    logic [CW-1:0]    r_count;
    logic signed [15:0] r_peak;
    logic [AW-1:0]    r_peak_idx;
    logic             r_drop;
    logic [AW-1:0]    r_scan;
    logic signed [15:0] r_rd_amp;
    logic [31:0]      r_rd_time;
    logic signed [15:0] r_a1, r_a0;
    logic [31:0]      r_t1, r_t0;
    logic signed [32:0] r_thr;
    logic [MAG_BITS-1:0] r_mag;
    logic             r_neg;
    logic [24:0]      r_den;

    logic             w_full;
    logic signed [32:0] w_rd_sc;
    logic [31:0]      w_numv;
    logic [31:0]      w_dmag;
    logic [QUOT_BITS-1:0] w_quot;
    logic             w_rem_nz;
    logic [QUOT_BITS-1:0] w_q;
    logic [39:0]      w_base;

    assign w_full  = (r_count == CW'(MAX_SAMPLES));
    assign w_rd_sc = {r_rd_amp[15], r_rd_amp, 16'd0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !w_full) begin
            mem_amp[r_count[AW-1:0]]  <= i_amp;
            mem_time[r_count[AW-1:0]] <= i_time;
        end
        if (i_cmd.rd_start) begin
            r_rd_amp  <= mem_amp[r_scan];
            r_rd_time <= mem_time[r_scan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count    <= '0;
            r_peak     <= PEAK_RESET;
            r_peak_idx <= '0;
            r_drop     <= 1'b0;
        end else if (i_cmd.store) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
                if ($signed(i_amp) > r_peak) begin
                    r_peak     <= $signed(i_amp);
                    r_peak_idx <= r_count[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan <= r_peak_idx;
            r_thr  <= $signed({1'b0, i_fraction}) * r_peak;
        end else if (i_cmd.scan_dec) begin
            r_scan <= r_scan - AW'(1);
        end
        if (i_cmd.lat_cur) begin
            r_a1 <= r_rd_amp;
            r_t1 <= r_rd_time;
        end
        if (i_cmd.lat_prev) begin
            r_a0 <= r_rd_amp;
            r_t0 <= r_rd_time;
        end
    end

    assign w_numv = 32'(r_thr - $signed({r_a0, 16'd0}));
    assign w_dmag = (r_t1 < r_t0) ? (r_t0 - r_t1) : (r_t1 - r_t0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            // numerator at most (a1-a0)*2^16 so fits in 32 bits
            r_mag <= w_numv * w_dmag;
            r_neg <= (r_t1 < r_t0);
            r_den <= {17'(r_a1 - r_a0), 8'd0};
        end
    end

    cfdt_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num    (r_mag),
        .i_den    (r_den),
        .o_quot   (w_quot),
        .o_rem_nz (w_rem_nz),
        .o_done   (o_stat.div_done)
    );

    assign w_q    = w_quot + QUOT_BITS'(r_neg && w_rem_nz);
    assign w_base = {r_t0, 8'd0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_found          <= i_cmd.res_found;
            o_cfd_time       <= !i_cmd.res_found ? 40'd0 :
                                r_neg ? w_base - w_q[39:0] : w_base + w_q[39:0];
            o_peak_amplitude <= r_peak;
            o_peak_index     <= 10'(r_peak_idx);
            o_overflow       <= r_drop;
        end
    end

    assign o_stat.can_scan  = (r_peak > 16'sd0) && (r_peak_idx != '0);
    assign o_stat.cur_ge    = w_rd_sc >= r_thr;
    assign o_stat.prev_lt   = w_rd_sc < r_thr;
    assign o_stat.scan_zero = (r_scan == '0);
    assign o_stat.scan_one  = (r_scan == AW'(1));
endmodule

FILE: sv/cfdt_ctrl.sv
// sequencer: sample load, backward scan, interpolation and result handoff
module cfdt_ctrl
    import cfdt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_last,
    input  logic  i_out_taken,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);
    localparam logic [3:0] S_LOAD = 4'd0, S_INIT = 4'd1, S_RDC = 4'd2, S_CHKC = 4'd3,
                           S_CHKP = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_WAIT = 4'd7,
                           S_OUT = 4'd8, S_RDCW = 4'd9, S_RDPW = 4'd10, S_RES = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_ov, n_ov;
    logic       w_res_free;

    // result register can be reloaded when empty or taken in this cycle
    assign w_res_free = !r_ov || i_out_taken;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        if (i_out_taken) n_ov = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.store = 1'b1;
                    if (i_last) n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (i_stat.can_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_RDC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RDC: begin
                o_cmd.rd_start = 1'b1;
                n_state = S_RDCW;
            end
            S_RDCW: n_state = S_CHKC;
            S_CHKC: begin
                o_cmd.lat_cur = 1'b1;
                if (i_stat.cur_ge) begin
                    o_cmd.scan_dec = 1'b1;
                    n_state = S_RDPW;
                end else if (i_stat.scan_one) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_dec = 1'b1;
                    n_state = S_RDC;
                end
            end
            S_RDPW: begin
                o_cmd.rd_start = 1'b1;
                n_state = S_CHKP;
            end
            S_CHKP: begin
                o_cmd.lat_prev = 1'b1;
                if (i_stat.prev_lt) n_state = S_MUL;
                else if (i_stat.scan_zero) n_state = S_OUT;
                else n_state = S_RDC;
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) n_state = S_RES;
            end
            S_RES: begin
                if (w_res_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_found = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (w_res_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;
endmodule

FILE: test/tb_top.sv
// self-checking testbench for the constant fraction edge timer
module tb_top;
    import cfdt_pkg::*;

    localparam logic [1:0] FRACTION_ADDR = 2'(4 * ADDR_FRACTION);
    localparam int STORE_DEPTH = 1024;
    localparam int RUN_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 4 * STORE_DEPTH + 80;

    // predicts the timing result of each waveform and checks what comes out
    class cfd_scoreboard;
        logic signed [15:0] amp_mem [STORE_DEPTH];
        logic [31:0] stamp_mem [STORE_DEPTH];
        int count;
        logic signed [15:0] peak;
        int peak_idx;
        bit dropped;
        logic [15:0] fraction;
        logic [71:0] pending_results [$];
        int errors;

        function new();
            fraction = FRACTION_RESET;
            errors = 0;
            count = 0;
            peak = PEAK_RESET;
            peak_idx = 0;
            dropped = 0;
        endfunction

        function void note_sample(logic signed [15:0] amp, logic [31:0] stamp, bit last);
            bit found;
            logic [39:0] when;
            longint thr, a0, a1, cur, prev;
            logic [31:0] t0, t1;
            logic [127:0] num, dv, mag, q;
            if (count < STORE_DEPTH) begin
                amp_mem[count] = amp;
                stamp_mem[count] = stamp;
                if (amp > peak) begin
                    peak = amp;
                    peak_idx = count;
                end
                count++;
            end else begin
                dropped = 1;
            end
            if (!last) return;
            found = 0;
            when = '0;
            if (peak > 0 && peak_idx >= 1) begin
                thr = longint'(fraction) * longint'(peak);
                for (int k = peak_idx; k >= 1; k--) begin
                    cur = longint'(amp_mem[k]) * 65536;
                    prev = longint'(amp_mem[k-1]) * 65536;
                    if (cur >= thr && prev < thr) begin
                        a0 = amp_mem[k-1];
                        a1 = amp_mem[k];
                        t0 = stamp_mem[k-1];
                        t1 = stamp_mem[k];
                        num = 128'(thr - a0 * 65536);
                        dv = 128'((a1 - a0) * 256);
                        mag = num * 128'((t1 < t0) ? t0 - t1 : t1 - t0);
                        q = mag / dv;
                        if (t1 < t0) begin
                            if (q * dv != mag) q = q + 1;
                            when = {t0, 8'h00} - q[39:0];
                        end else begin
                            when = {t0, 8'h00} + q[39:0];
                        end
                        found = 1;
                        break;
                    end
                end
            end
            pending_results.insert(pending_results.size(),
                                   {4'b0, dropped, 10'(peak_idx), peak, when, found});
            count = 0;
            peak = PEAK_RESET;
            peak_idx = 0;
            dropped = 0;
        endfunction

        function void check_result(logic [71:0] got);
            logic [71:0] want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got[0] !== want[0] || got[40:1] !== want[40:1] || got[56:41] !== want[56:41]
                || got[66:57] !== want[66:57] || got[67] !== want[67]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: found %b/%b time %h/%h peak %h/%h idx %0d/%0d ovf %b/%b",
                             want[0], got[0], want[40:1], got[40:1], want[56:41], got[56:41],
                             want[66:57], got[66:57], want[67], got[67]);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // sample_amplitude[15:0], sample_time[47:16]
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;        // found[0], cfd_time[40:1], peak_amplitude[56:41],
                                      // peak_index[66:57], overflow[67]
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    constant_fraction_edge_timer dut (.*);

    always #2 i_clk = ~i_clk;

    cfd_scoreboard sb = new();
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 0;
    int hold_left = 0;
    int sent_items = 0;
    int cycle_count = 0;

    logic signed [15:0] wave_amp [1100];
    logic [31:0] wave_stamp [1100];

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: long hold-off on request, else random stalls
    always @(negedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left <= 3000;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk)
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    task automatic send_sample(logic signed [15:0] amp, logic [31:0] stamp, bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {stamp, amp};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(amp, stamp, last);
        sent_items++;
    endtask

    task automatic send_wave(int n);
        for (int i = 0; i < n; i++) send_sample(wave_amp[i], wave_stamp[i], i == n - 1);
    endtask

    task automatic write_fraction(logic [15:0] value);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= FRACTION_ADDR; pwdata <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (prdata[15:0] !== value) begin
            sb.errors++;
            if (sb.errors <= 10) $display("fraction readback %h, wrote %h", prdata, value);
        end
        @(negedge i_clk);
        psel <= 0; penable <= 0;
        sb.fraction = value;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // shaped pulse (baseline, rise, decay), random or negative; some scrambled stamps
    task automatic random_wave(int kind);
        int b, r, f, n, p;
        logic [31:0] t;
        b = $urandom_range(0, 6);
        r = $urandom_range(1, 8);
        f = $urandom_range(0, 10);
        n = b + r + f;
        p = $urandom_range(1, 32767);
        t = $urandom;
        for (int i = 0; i < n; i++) begin
            if (kind == 7) wave_amp[i] = 16'($urandom);
            else if (kind == 8) wave_amp[i] = -16'($urandom_range(0, 32768));
            else if (i < b) wave_amp[i] = 16'(int'($urandom_range(0, 40)) - 20);
            else if (i < b + r) wave_amp[i] = 16'(p * (i - b + 1) / r);
            else wave_amp[i] = 16'(p - p * (i - b - r + 1) / (f + 1));
            wave_stamp[i] = t;
            t = (kind == 9) ? $urandom : t + $urandom_range(1, 4000);
        end
        send_wave(n);
    endtask

    initial begin
        logic [15:0] fractions [4];
        fractions = '{16'd0, 16'hFFFF, 16'h8000, 16'h0000};
        fractions[3] = 16'($urandom_range(1, 65534));
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // default fraction of one half
        send_sample(100, 5, 1);                                   // one sample, peak at zero
        wave_amp[0] = -32768; wave_amp[1] = 32767;
        wave_stamp[0] = 0; wave_stamp[1] = 32'hFFFFFFFF;
        send_wave(2);                                             // full-range crossing
        wave_amp[0] = -5; wave_amp[1] = -3; wave_amp[2] = -7;
        wave_stamp[0] = 1; wave_stamp[1] = 2; wave_stamp[2] = 3;
        send_wave(3);                                             // peak not positive
        wave_amp[0] = 500; wave_amp[1] = 100; wave_amp[2] = 200;
        send_wave(3);                                             // peak first
        wave_amp[0] = 20; wave_amp[1] = 25; wave_amp[2] = 30;
        send_wave(3);                                             // nothing below threshold
        wave_amp[0] = 0; wave_amp[1] = 100; wave_amp[2] = 40;
        wave_stamp[0] = 1000; wave_stamp[1] = 10; wave_stamp[2] = 5;
        send_wave(3);                                             // time stamps going back
        wave_amp[0] = 0; wave_amp[1] = 7;
        wave_stamp[0] = 1; wave_stamp[1] = 0;
        send_wave(2);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_fraction(fractions[ph]);
            sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 9) : 0;
            recv_stall_pct = (ph == 2) ? 58 : ((ph == 3) ? 9 : 0);
            for (int w = 0; sent_items < 20 + 260 * (ph + 1); w++) begin
                if (ph == 0 && w == 5) hold_request = 1;
                if (ph == 0 && w == 6) hold_request = 0;
                random_wave($urandom_range(0, 9));
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
